### src/hhq_pkg.sv
// shared constants for the heightfield height query block
package hhq_pkg;

  localparam int unsigned GridPointsDefault = 64;
  localparam int unsigned SpacingWidth      = 25;
  localparam int unsigned HeightWidth       = 32;
  localparam int unsigned PosWidth          = 32;
  localparam logic [SpacingWidth-1:0] SpacingReset = 25'd786432;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

endpackage

### src/hhq_ram.sv
// generic single-port ram with registered read
module hhq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### src/hhq_div.sv
// restoring bit-serial floor divider, unsigned divisor, signed dividend
module hhq_div #(
  parameter int unsigned NumWidth = 64,
  parameter int unsigned DenWidth = 27
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [NumWidth-1:0]  num_i,
  input  logic [DenWidth-1:0]         den_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic signed [NumWidth-1:0]  quo_o
);
  import hhq_pkg::*;

  localparam int unsigned CntWidth = $clog2(NumWidth + 1);

  logic [NumWidth-1:0]   mag_q, mag_d;
  logic [DenWidth:0]     rem_q, rem_d;
  logic [DenWidth-1:0]   den_q, den_d;
  logic                  neg_q, neg_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  busy_q, busy_d, done_q, done_d;
  logic [DenWidth+1:0]   trial;
  logic                  rem_nz;
  logic [NumWidth-1:0]   q_adj;

  // floor of a negative quotient: -(|n| div d) minus one if remainder nonzero
  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, mag_q[NumWidth-1]} - {2'b00, den_q};
    if (start_i) begin
      neg_d  = num_i[NumWidth-1];
      mag_d  = num_i[NumWidth-1] ? NumWidth'(-num_i) : NumWidth'(num_i);
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntWidth'(NumWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DenWidth+1]) begin
        rem_d = trial[DenWidth:0];
        mag_d = {mag_q[NumWidth-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DenWidth-1:0], mag_q[NumWidth-1]};
        mag_d = {mag_q[NumWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign rem_nz = (rem_q != '0);
  assign q_adj  = neg_q ? (~mag_q + NumWidth'(rem_nz ? 0 : 1)) : mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = signed'(q_adj);

  always @(posedge clk_i) begin
    if (rst_ni && start_i) assert (!busy_q) else $error("divider restarted while busy");
  end
endmodule

### src/heightfield_height_query.sv
// heightfield height query: top level, store, sequencer and plane solve
// a write is stored at its input transfer; a query runs the row and column divides,
// the corner fetch, the multiply and the height divide (66-bit divides in hhq_div,
// one quotient bit per cycle), then the output load. writes are taken one per cycle
// while idle; a new query waits until the last result is loaded, and a waiting
// result stalls only the next query's output load. reset clears control state and
// sets cell spacing to 12.0; the height store is undefined until written
module heightfield_height_query #(
  parameter int unsigned GridPoints = hhq_pkg::GridPointsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hhq_pkg::SpacingWidth-1:0]   cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic [$clog2(GridPoints)-1:0]      grid_row_i,
  input  logic [$clog2(GridPoints)-1:0]      grid_col_i,
  input  logic signed [31:0]                 height_value_i,
  input  logic signed [31:0]                 pos_x_i,
  input  logic signed [31:0]                 pos_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [31:0]                 terrain_height_o,
  output logic                               out_of_grid_o,
  output logic                               upper_triangle_o
);
  import hhq_pkg::*;

  localparam int unsigned IdxW  = $clog2(GridPoints);
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned Half  = GridPoints / 2;
  localparam int unsigned DivNW = 66;
  localparam int unsigned DivDW = 27;

  // sequencer states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDivR  = 4'd1;
  localparam logic [3:0] StDivC  = 4'd2;
  localparam logic [3:0] StRd    = 4'd3;
  localparam logic [3:0] StMul0  = 4'd4;
  localparam logic [3:0] StMul1  = 4'd5;
  localparam logic [3:0] StDivY  = 4'd6;
  localparam logic [3:0] StOut   = 4'd7;
  localparam logic [3:0] StMulD  = 4'd9;

  logic [3:0]              st_q, st_d;
  logic [SpacingWidth-1:0] spacing_q;
  logic [SpacingWidth-1:0] s_eff;

  // item registers
  logic signed [31:0] px_q, pz_q;
  logic signed [33:0] r_q, c_q;
  logic signed [34:0] dx_q, dz_q;
  logic signed [32:0] h_q [4];
  logic [2:0]         rd_cnt_q;
  logic signed [65:0] num_q;
  logic               upper_q;
  logic signed [65:0] prod_a_q, prod_b_q;

  // output register
  logic               ovalid_q;
  logic signed [31:0] oheight_q;
  logic               ogrid_q, oupper_q;

  // divider
  logic                div_start, div_busy, div_done;
  logic signed [65:0]  dnum;
  logic [DivDW-1:0]    dden;
  logic signed [65:0]  dquo;

  // ram
  logic              ram_we;
  logic [AddrW-1:0]  ram_addr;
  logic [31:0]       ram_rdata;

  logic in_xfer, out_xfer;
  logic [IdxW:0]      rr, cc;
  logic               in_grid;
  logic signed [34:0] x1, z1;
  logic signed [65:0] y_full;

  assign s_eff    = (spacing_q == '0) ? SpacingWidth'(1) : spacing_q;
  assign in_stall_o = (st_q != StIdle);
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = ovalid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= SpacingReset;
    end else if (cfg_we_i) begin
      spacing_q <= cfg_wdata_i;
    end
  end

  // cell index range check on the floor quotients
  assign in_grid = (r_q >= 0) && (r_q <= 34'(GridPoints - 2))
                && (c_q >= 0) && (c_q <= 34'(GridPoints - 2));
  assign rr = r_q[IdxW:0];
  assign cc = c_q[IdxW:0];

  // corner fetch order h0 (r,c), h1 (r+1,c), h2 (r,c+1), h3 (r+1,c+1)
  always_comb begin
    logic [IdxW-1:0] ra, ca;
    ra = rr[IdxW-1:0] + IdxW'(rd_cnt_q[0]);
    ca = cc[IdxW-1:0] + IdxW'(rd_cnt_q[1]);
    ram_addr = {ra, ca};
    ram_we   = 1'b0;
    if (st_q == StIdle) begin
      ram_addr = {grid_row_i, grid_col_i};
      ram_we   = in_xfer && (opcode_i == OpWrite);
    end
  end

  hhq_ram #(.Width(32), .Depth(GridPoints * GridPoints)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (height_value_i),
    .rdata_o (ram_rdata)
  );

  // world position of grid corner h1 (r+1, c); dx and dz are the query point relative to it
  assign x1 = 35'(signed'(r_q + 34'sd1 - 34'(Half))) * 35'(signed'({1'b0, s_eff}));
  assign z1 = -(35'(signed'(c_q - 34'(Half))) * 35'(signed'({1'b0, s_eff})));

  // divider operand select: numerator of the rounded divide is 2*num + s
  always_comb begin
    div_start = 1'b0;
    dnum = 66'(px_q);
    dden = DivDW'(s_eff);
    case (st_q)
      StIdle: begin
        dnum = 66'(pos_x_i);
        div_start = in_xfer && (opcode_i == OpQuery);
      end
      StDivR: begin
        dnum = -66'(pz_q);
        div_start = div_done;
      end
      StMulD: begin
        dnum = (num_q <<< 1) + 66'(signed'({1'b0, s_eff}));
        dden = {1'b0, s_eff, 1'b0};
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  hhq_div #(.NumWidth(DivNW), .DenWidth(DivDW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dnum),
    .den_i   (dden),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (dquo)
  );

  assign y_full = dquo + 66'(h_q[1]);

  // the output register parts the sides: back to idle once the result is loaded
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (in_xfer && opcode_i == OpQuery) st_d = StDivR;
      StDivR:  if (div_done) st_d = StDivC;
      StDivC:  if (div_done) st_d = StRd;
      StRd:    if (!in_grid || rd_cnt_q == 3'd4) st_d = in_grid ? StMul0 : StOut;
      StMul0:  st_d = StMul1;
      StMul1:  st_d = StMulD;
      StMulD:  st_d = StDivY;
      StDivY:  if (div_done) st_d = StOut;
      StOut:   if (!ovalid_q || out_xfer) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      ovalid_q <= 1'b0;
      rd_cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (out_xfer) ovalid_q <= 1'b0;
      if (st_q == StOut && (!ovalid_q || out_xfer)) ovalid_q <= 1'b1;
      if (st_q == StDivC) rd_cnt_q <= '0;
      else if (st_q == StRd && in_grid) rd_cnt_q <= rd_cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      px_q <= pos_x_i;
      pz_q <= pos_z_i;
    end
    if (st_q == StDivR && div_done) r_q <= dquo[33:0] + 34'(Half);
    if (st_q == StDivC && div_done) c_q <= dquo[33:0] + 34'(Half);
    if (st_q == StRd) begin
      dx_q <= 35'(px_q) - x1;
      dz_q <= 35'(pz_q) - z1;
      // read data comes back in the cycle after its address
      if (rd_cnt_q != 3'd0) h_q[rd_cnt_q[1:0] - 2'd1] <= 33'(signed'(ram_rdata));
    end
    if (st_q == StMul0) begin
      upper_q <= dz_q > dx_q;
      if (dz_q > dx_q) begin
        prod_a_q <= 66'(dz_q) * 66'(h_q[0] - h_q[2]);
        prod_b_q <= 66'(dx_q) * 66'(h_q[0] - h_q[1]);
      end else begin
        prod_a_q <= 66'(dx_q) * 66'(h_q[3] - h_q[2]);
        prod_b_q <= 66'(dz_q) * 66'(h_q[3] - h_q[1]);
      end
    end
    if (st_q == StMul1) num_q <= prod_a_q - prod_b_q;
    if (st_q == StOut && (!ovalid_q || out_xfer)) begin
      if (!in_grid) begin
        oheight_q <= '0;
        ogrid_q   <= 1'b1;
        oupper_q  <= 1'b0;
      end else begin
        ogrid_q  <= 1'b0;
        oupper_q <= upper_q;
        if (y_full > 66'sd2147483647) oheight_q <= 32'sh7fffffff;
        else if (y_full < -66'sd2147483648) oheight_q <= 32'sh80000000;
        else oheight_q <= y_full[31:0];
      end
    end
  end

  assign out_valid_o      = ovalid_q;
  assign terrain_height_o = oheight_q;
  assign out_of_grid_o    = ogrid_q;
  assign upper_triangle_o = oupper_q;

  ap_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> in_stall_o) else $error("transfer taken while busy");
  ap_grid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_grid_o) |-> (terrain_height_o == '0 && !upper_triangle_o))
    else $error("out-of-grid result not zero");
  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(terrain_height_o))
    else $error("stalled result changed");
  ap_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider started while busy");
endmodule

### sim/tb_heightfield_height_query.sv
// testbench for the heightfield height query block: directed and random writes and queries
module tb_heightfield_height_query;
  timeunit 1ns;
  timeprecision 1ps;
  import hhq_pkg::*;

  localparam int Points = 64;
  localparam int Half = Points / 2;
  localparam int IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [SpacingWidth-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic opcode_i = OpWrite;
  logic [5:0] grid_row_i = '0;
  logic [5:0] grid_col_i = '0;
  logic signed [31:0] height_value_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] terrain_height_o;
  logic out_of_grid_o;
  logic upper_triangle_o;

  typedef struct packed {
    logic signed [31:0] height;
    logic off_grid;
    logic upper;
  } height_result_t;

  // predictor state: shadow of the height store and the spacing register
  logic signed [31:0] heights [Points*Points];
  bit written [Points*Points];
  logic [SpacingWidth-1:0] spacing;
  height_result_t pending_heights [$];

  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  heightfield_height_query uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .opcode_i, .grid_row_i, .grid_col_i, .height_value_i, .pos_x_i, .pos_z_i,
    .out_valid_o, .out_stall_i, .terrain_height_o, .out_of_grid_o, .upper_triangle_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // floor division for a positive divisor
  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // expected result of a query at the current spacing and store contents
  function automatic height_result_t terrain_at(logic signed [31:0] px, logic signed [31:0] pz);
    height_result_t res;
    longint s, r, c, dx, dz, h0, h1, h2, h3, num, y;
    s = longint'(spacing);
    if (s == 0) s = 1;
    r = floor_quot(longint'(px), s) + Half;
    c = floor_quot(-longint'(pz), s) + Half;
    res = '0;
    if (r < 0 || r > Points - 2 || c < 0 || c > Points - 2) begin
      res.off_grid = 1'b1;
      return res;
    end
    dx = longint'(px) - (r + 1 - Half) * s;
    dz = longint'(pz) + (c - Half) * s;
    h0 = heights[r*Points+c];
    h1 = heights[(r+1)*Points+c];
    h2 = heights[r*Points+c+1];
    h3 = heights[(r+1)*Points+c+1];
    res.upper = dz > dx;
    if (res.upper) num = dz * (h0 - h2) - dx * (h0 - h1);
    else num = dx * (h3 - h2) - dz * (h3 - h1);
    y = floor_quot(2 * num + s, 2 * s) + h1;
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    res.height = y[31:0];
    return res;
  endfunction

  // random idle burst on the sender side; valid drops for the burst
  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // one input transfer; the prediction is made when the transfer is accepted
  // valid stays up so that the next item can follow at once
  task automatic send_item(logic op, logic [5:0] row, logic [5:0] col,
                           logic signed [31:0] hv, logic signed [31:0] px,
                           logic signed [31:0] pz);
    sender_gap();
    in_valid_i <= 1'b1;
    opcode_i <= op;
    grid_row_i <= row;
    grid_col_i <= col;
    height_value_i <= hv;
    pos_x_i <= px;
    pos_z_i <= pz;
    do @(posedge clk_i); while (in_stall_o);
    if (op == OpWrite) begin
      heights[row*Points+col] = hv;
      written[row*Points+col] = 1'b1;
    end else begin
      pending_heights.push_back(terrain_at(px, pz));
    end
    items_sent++;
  endtask

  task automatic write_height(int row, int col, logic signed [31:0] hv);
    send_item(OpWrite, row[5:0], col[5:0], hv, $urandom, $urandom);
  endtask

  task automatic query_at(logic signed [31:0] px, logic signed [31:0] pz);
    send_item(OpQuery, 6'($urandom), 6'($urandom), $urandom, px, pz);
  endtask

  // wait for every expected result, then let the block settle before a register write
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic set_spacing(logic [SpacingWidth-1:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    spacing = value;
  endtask

  // true when the position is off the grid or all four corners of its cell were written
  function automatic bit corners_known(logic signed [31:0] px, logic signed [31:0] pz);
    longint s, r, c;
    s = longint'(spacing);
    if (s == 0) s = 1;
    r = floor_quot(longint'(px), s) + Half;
    c = floor_quot(-longint'(pz), s) + Half;
    if (r < 0 || r > Points - 2 || c < 0 || c > Points - 2) return 1'b1;
    return written[r*Points+c] && written[(r+1)*Points+c] &&
           written[r*Points+c+1] && written[(r+1)*Points+c+1];
  endfunction

  // position inside cell (r, c), offset by frac from the cell's corner along that axis
  function automatic logic signed [31:0] x_in_cell(int r, longint frac);
    return 32'((longint'(r) - Half) * longint'(spacing) + frac);
  endfunction

  function automatic logic signed [31:0] z_in_cell(int c, longint frac);
    return 32'(-((longint'(c) - Half) * longint'(spacing) + frac));
  endfunction

  // write extreme heights, hit both triangles, the diagonal, edges and off-grid spots
  task automatic test_directed();
    write_height(0, 0, 32'sh7fffffff);
    write_height(1, 0, 32'sh80000000);
    write_height(0, 1, 32'sh80000000);
    write_height(1, 1, 32'sh7fffffff);
    write_height(32, 32, 32'sh00010000);
    write_height(33, 32, 32'sh00020000);
    write_height(32, 33, -32'sh00030000);
    write_height(33, 33, 32'sh0);
    write_height(62, 62, 32'sh55555555);
    write_height(63, 62, 32'shaaaaaaaa);
    write_height(62, 63, 32'sh0000ffff);
    write_height(63, 63, 32'shffff0000);
    query_at(x_in_cell(32, 1), z_in_cell(32, 2));
    query_at(x_in_cell(32, 600000), z_in_cell(32, 100));
    query_at(x_in_cell(32, 393216), z_in_cell(32, 393216));
    query_at(x_in_cell(0, 0), z_in_cell(0, 0));
    query_at(x_in_cell(0, 786431), z_in_cell(0, 786431));
    query_at(x_in_cell(0, 100000), z_in_cell(0, 700000));
    query_at(x_in_cell(62, 5), z_in_cell(62, 786000));
    query_at(x_in_cell(63, 0), z_in_cell(32, 5));
    query_at(x_in_cell(32, 5), z_in_cell(63, 0));
    query_at(x_in_cell(0, -1), z_in_cell(32, 5));
    query_at(32'sh7fffffff, 32'sh80000000);
    query_at(32'sh80000000, 32'sh7fffffff);
  endtask

  // spacing register at both extremes and zero
  task automatic test_spacing_extremes();
    set_spacing(25'h1ffffff);
    query_at(32'sh0, 32'sh0);
    query_at(32'sh7fffffff, 32'sh80000001);
    set_spacing(25'd0);
    query_at(32'sh0, 32'sh0);
    // cell (32, 33) needs its far corners
    write_height(32, 34, 32'sh00001000);
    write_height(33, 34, -32'sh00002000);
    query_at(32'sh0, -32'sd1);
    query_at(-32'sd32, 32'sd32);
    set_spacing(25'd1);
    query_at(32'sd30, -32'sd30);
    query_at(32'sd31, -32'sd31);
  endtask

  // fill a patch of the grid so that random queries land on known corners
  task automatic fill_patch(int r0, int c0, int n);
    for (int r = r0; r < r0 + n && r < Points; r++)
      for (int c = c0; c < c0 + n && c < Points; c++)
        if (!written[r*Points+c]) write_height(r, c, $urandom);
  endtask

  task automatic random_query_burst(int count, int r0, int c0, int n);
    logic signed [31:0] px, pz;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        px = $urandom;
        pz = $urandom;
      end else begin
        px = x_in_cell($urandom_range(r0, r0 + n - 2), $urandom_range(0, spacing));
        pz = z_in_cell($urandom_range(c0, c0 + n - 2), $urandom_range(0, spacing));
      end
      if (corners_known(px, pz)) query_at(px, pz);
      else write_height($urandom_range(r0, r0 + n - 1), $urandom_range(c0, c0 + n - 1),
                        $urandom);
      if ($urandom_range(0, 7) == 0)
        write_height($urandom_range(r0, r0 + n - 1), $urandom_range(c0, c0 + n - 1),
                     $urandom);
    end
  endtask

  // random mix over several spacings, the last part without idling
  task automatic test_random();
    set_spacing(25'd786432);
    fill_patch(26, 26, 12);
    random_query_burst(120, 26, 26, 12);
    // sender holds off until every result has come back
    drain();
    set_spacing($urandom_range(1, 25'h1ffffff));
    random_query_burst(80, 26, 26, 12);
    set_spacing(25'd3);
    random_query_burst(80, 26, 26, 12);
    set_spacing(25'd65536);
    fill_patch(56, 56, 8);
    random_query_burst(40, 56, 56, 8);
    idle_on = 1'b0;
    random_query_burst(60, 56, 56, 8);
  endtask

  // result side: random stall bursts and comparison against the oldest expectation
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      height_result_t want;
      results_seen++;
      if (pending_heights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: height %0d", terrain_height_o);
      end else begin
        want = pending_heights.pop_front();
        if (want.height !== terrain_height_o || want.off_grid !== out_of_grid_o ||
            want.upper !== upper_triangle_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected h=%0d off=%0b up=%0b got h=%0d off=%0b up=%0b",
                     want.height, want.off_grid, want.upper,
                     terrain_height_o, out_of_grid_o, upper_triangle_o);
        end
      end
    end
  end

  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 14);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IdleLimit) begin
      $display("tb_heightfield_height_query NOT OK");
      $finish;
    end
  end

  initial begin
    spacing = SpacingReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_spacing_extremes();
    test_random();
    drain();
    $display("sent %0d items (writes and queries) over several spacings, checked %0d heights",
             items_sent, results_seen);
    if (mismatches == 0 && pending_heights.size() == 0) begin
      $display("tb_heightfield_height_query OK");
    end else begin
      $display("tb_heightfield_height_query NOT OK");
    end
    $finish;
  end
endmodule

### files.f
src/hhq_pkg.sv
src/hhq_ram.sv
src/hhq_div.sv
src/heightfield_height_query.sv
sim/tb_heightfield_height_query.sv
